@@ rtl/core/mtcp_pkg.sv @@
// Shared types, codes and constants for the MIDI track chunk parser.
// No dependencies; used by every module of the block but the input register.
package mtcp_pkg;

   typedef enum logic [9:0] {
      PH_HDR     = 10'b00_0000_0001,
      PH_HDR_BAD = 10'b00_0000_0010,
      PH_DELTA   = 10'b00_0000_0100,
      PH_STATUS  = 10'b00_0000_1000,
      PH_DATA1   = 10'b00_0001_0000,
      PH_DATA2   = 10'b00_0010_0000,
      PH_META    = 10'b00_0100_0000,
      PH_LEN     = 10'b00_1000_0000,
      PH_SKIP    = 10'b01_0000_0000,
      PH_DRAIN   = 10'b10_0000_0000
   } phase_type;

   localparam logic [1:0] EV_NOTE_OFF = 2'd0;
   localparam logic [1:0] EV_NOTE_ON  = 2'd1;
   localparam logic [1:0] EV_END      = 2'd2;
   localparam logic [1:0] EV_BAD_HDR  = 2'd3;

   localparam logic [7:0] ST_SYSEX     = 8'hF0;
   localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
   localparam logic [7:0] ST_META      = 8'hFF;
   localparam logic [7:0] META_EOT     = 8'h2F;
   localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
   localparam logic [3:0] HI_NOTE_ON   = 4'h9;
   localparam logic [3:0] HI_PROGRAM   = 4'hC;
   localparam logic [3:0] HI_PRESSURE  = 4'hD;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [3:0]  channel;
      logic [31:0] start_tick;
      logic [6:0]  key;
      logic [6:0]  velocity;
      logic [15:0] track_number;
      logic [31:0] note_count;
   } result_type;

   function automatic logic [7:0] tag_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h4D;
         2'd1:    b = 8'h54;
         2'd2:    b = 8'h72;
         default: b = 8'h6B;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/core/mtcp_input_stage.sv @@
// Input register of the MIDI track chunk parser.
// Holds one accepted byte until the parser takes it; no package use.
module mtcp_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_start,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_data_byte,
   output logic       item_stream_start
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       start_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff  <= req_data_byte;
         start_ff <= req_stream_start;
      end
   end

   assign item_valid        = valid_ff;
   assign item_data_byte    = data_ff;
   assign item_stream_start = start_ff;

endmodule

@@ rtl/core/mtcp_parser.sv @@
// Parser state and single-byte update logic of the MIDI track chunk parser.
// Depends on mtcp_pkg for the phase type, event codes and result struct.
module mtcp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                stream_start,
   output logic                res_valid,
   output mtcp_pkg::result_type res
);

   mtcp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [2:0]  header_index_ff, header_index_in, header_index_cur;
   logic [31:0] chunk_length_ff, chunk_length_in, chunk_length_cur;
   logic [31:0] bytes_consumed_ff, bytes_consumed_in, bytes_consumed_cur;
   logic [7:0]  running_status_ff, running_status_in, running_status_cur;
   logic [31:0] length_acc_ff, length_acc_in, length_acc_cur;
   logic [31:0] absolute_tick_ff, absolute_tick_in, absolute_tick_cur;
   logic [6:0]  first_data_ff, first_data_in, first_data_cur;
   logic [31:0] skip_remaining_ff, skip_remaining_in, skip_remaining_cur;
   logic [7:0]  meta_kind_ff, meta_kind_in, meta_kind_cur;
   logic [15:0] track_index_ff, track_index_in, track_index_cur;
   logic [31:0] notes_seen_ff, notes_seen_in, notes_seen_cur;

   logic [31:0] acc_shift;
   logic [31:0] bytes_next;
   logic        one_data;

   assign phase_cur          = stream_start ? mtcp_pkg::PH_HDR : phase_ff;
   assign header_index_cur   = stream_start ? 3'd0  : header_index_ff;
   assign chunk_length_cur   = stream_start ? 32'd0 : chunk_length_ff;
   assign bytes_consumed_cur = stream_start ? 32'd0 : bytes_consumed_ff;
   assign running_status_cur = stream_start ? 8'd0  : running_status_ff;
   assign length_acc_cur     = stream_start ? 32'd0 : length_acc_ff;
   assign absolute_tick_cur  = stream_start ? 32'd0 : absolute_tick_ff;
   assign first_data_cur     = stream_start ? 7'd0  : first_data_ff;
   assign skip_remaining_cur = stream_start ? 32'd0 : skip_remaining_ff;
   assign meta_kind_cur      = stream_start ? 8'd0  : meta_kind_ff;
   assign track_index_cur    = stream_start ? 16'd0 : track_index_ff;
   assign notes_seen_cur     = stream_start ? 32'd0 : notes_seen_ff;

   assign acc_shift  = {length_acc_cur[24:0], data_byte[6:0]};
   assign bytes_next = bytes_consumed_cur + 32'd1;
   assign one_data   = (running_status_cur[7:4] == mtcp_pkg::HI_PROGRAM) ||
                       (running_status_cur[7:4] == mtcp_pkg::HI_PRESSURE);

   always_comb begin
      phase_in          = phase_cur;
      header_index_in   = header_index_cur;
      chunk_length_in   = chunk_length_cur;
      bytes_consumed_in = bytes_consumed_cur;
      running_status_in = running_status_cur;
      length_acc_in     = length_acc_cur;
      absolute_tick_in  = absolute_tick_cur;
      first_data_in     = first_data_cur;
      skip_remaining_in = skip_remaining_cur;
      meta_kind_in      = meta_kind_cur;
      track_index_in    = track_index_cur;
      notes_seen_in     = notes_seen_cur;
      res_valid         = 1'b0;
      res.event_kind    = mtcp_pkg::EV_NOTE_OFF;
      res.channel       = 4'd0;
      res.start_tick    = 32'd0;
      res.key           = 7'd0;
      res.velocity      = 7'd0;
      res.track_number  = track_index_cur;
      res.note_count    = notes_seen_cur;

      if (phase_cur == mtcp_pkg::PH_HDR || phase_cur == mtcp_pkg::PH_HDR_BAD) begin
         if (header_index_cur[2]) begin
            chunk_length_in = {chunk_length_cur[23:0], data_byte};
         end else begin
            if (data_byte != mtcp_pkg::tag_byte(header_index_cur[1:0])) begin
               phase_in = mtcp_pkg::PH_HDR_BAD;
            end
            if (header_index_cur == 3'd0) begin
               chunk_length_in = 32'd0;
            end
         end
         if (header_index_cur == 3'd7) begin
            header_index_in = 3'd0;
            if (phase_in == mtcp_pkg::PH_HDR_BAD) begin
               res_valid      = 1'b1;
               res.event_kind = mtcp_pkg::EV_BAD_HDR;
               phase_in       = mtcp_pkg::PH_HDR;
            end else if (chunk_length_in == 32'd0) begin
               track_index_in = track_index_cur + 16'd1;
            end else begin
               bytes_consumed_in = 32'd0;
               absolute_tick_in  = 32'd0;
               running_status_in = 8'd0;
               length_acc_in     = 32'd0;
               phase_in          = mtcp_pkg::PH_DELTA;
            end
         end else begin
            header_index_in = header_index_cur + 3'd1;
         end
      end else begin
         case (phase_cur)
            mtcp_pkg::PH_DELTA: begin
               length_acc_in = acc_shift;
               if (!data_byte[7]) begin
                  absolute_tick_in = absolute_tick_cur + acc_shift;
                  phase_in         = mtcp_pkg::PH_STATUS;
               end
            end
            mtcp_pkg::PH_STATUS: begin
               if (!data_byte[7]) begin
                  if (running_status_cur != 8'd0) begin
                     first_data_in = data_byte[6:0];
                     if (one_data) begin
                        length_acc_in = 32'd0;
                        phase_in      = mtcp_pkg::PH_DELTA;
                     end else begin
                        phase_in = mtcp_pkg::PH_DATA2;
                     end
                  end else begin
                     length_acc_in = 32'd0;
                     phase_in      = mtcp_pkg::PH_DELTA;
                  end
               end else if (data_byte < mtcp_pkg::ST_SYSEX) begin
                  running_status_in = data_byte;
                  phase_in          = mtcp_pkg::PH_DATA1;
               end else begin
                  running_status_in = 8'd0;
                  length_acc_in     = 32'd0;
                  if (data_byte == mtcp_pkg::ST_META) begin
                     phase_in = mtcp_pkg::PH_META;
                  end else if (data_byte == mtcp_pkg::ST_SYSEX ||
                               data_byte == mtcp_pkg::ST_SYSEX_ESC) begin
                     phase_in = mtcp_pkg::PH_LEN;
                  end else begin
                     phase_in = mtcp_pkg::PH_DELTA;
                  end
               end
            end
            mtcp_pkg::PH_DATA1: begin
               first_data_in = data_byte[6:0];
               if (one_data) begin
                  length_acc_in = 32'd0;
                  phase_in      = mtcp_pkg::PH_DELTA;
               end else begin
                  phase_in = mtcp_pkg::PH_DATA2;
               end
            end
            mtcp_pkg::PH_DATA2: begin
               res.channel    = running_status_cur[3:0];
               res.start_tick = absolute_tick_cur;
               res.key        = first_data_cur;
               res.velocity   = data_byte[6:0];
               if (running_status_cur[7:4] == mtcp_pkg::HI_NOTE_OFF) begin
                  res_valid = 1'b1;
               end else if (running_status_cur[7:4] == mtcp_pkg::HI_NOTE_ON) begin
                  res_valid = 1'b1;
                  if (data_byte[6:0] != 7'd0) begin
                     notes_seen_in  = notes_seen_cur + 32'd1;
                     res.event_kind = mtcp_pkg::EV_NOTE_ON;
                     res.note_count = notes_seen_cur + 32'd1;
                  end
               end
               length_acc_in = 32'd0;
               phase_in      = mtcp_pkg::PH_DELTA;
            end
            mtcp_pkg::PH_META: begin
               meta_kind_in = data_byte;
               if (data_byte == mtcp_pkg::META_EOT) begin
                  res_valid      = 1'b1;
                  res.event_kind = mtcp_pkg::EV_END;
                  res.start_tick = absolute_tick_cur;
                  phase_in       = mtcp_pkg::PH_DRAIN;
               end else begin
                  length_acc_in = 32'd0;
                  phase_in      = mtcp_pkg::PH_LEN;
               end
            end
            mtcp_pkg::PH_LEN: begin
               length_acc_in = acc_shift;
               if (!data_byte[7]) begin
                  skip_remaining_in = acc_shift;
                  if (acc_shift == 32'd0) begin
                     length_acc_in = 32'd0;
                     phase_in      = mtcp_pkg::PH_DELTA;
                  end else begin
                     phase_in = mtcp_pkg::PH_SKIP;
                  end
               end
            end
            mtcp_pkg::PH_SKIP: begin
               skip_remaining_in = skip_remaining_cur - 32'd1;
               if (skip_remaining_cur == 32'd1) begin
                  length_acc_in = 32'd0;
                  phase_in      = mtcp_pkg::PH_DELTA;
               end
            end
            default: begin
               phase_in = mtcp_pkg::PH_DRAIN;
            end
         endcase

         bytes_consumed_in = bytes_next;
         if (bytes_next == chunk_length_cur) begin
            track_index_in    = track_index_cur + 16'd1;
            phase_in          = mtcp_pkg::PH_HDR;
            header_index_in   = 3'd0;
            absolute_tick_in  = 32'd0;
            running_status_in = 8'd0;
            length_acc_in     = 32'd0;
            skip_remaining_in = 32'd0;
            bytes_consumed_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= mtcp_pkg::PH_HDR;
         header_index_ff   <= 3'd0;
         chunk_length_ff   <= 32'd0;
         bytes_consumed_ff <= 32'd0;
         running_status_ff <= 8'd0;
         length_acc_ff     <= 32'd0;
         absolute_tick_ff  <= 32'd0;
         first_data_ff     <= 7'd0;
         skip_remaining_ff <= 32'd0;
         meta_kind_ff      <= 8'd0;
         track_index_ff    <= 16'd0;
         notes_seen_ff     <= 32'd0;
      end else if (step) begin
         phase_ff          <= phase_in;
         header_index_ff   <= header_index_in;
         chunk_length_ff   <= chunk_length_in;
         bytes_consumed_ff <= bytes_consumed_in;
         running_status_ff <= running_status_in;
         length_acc_ff     <= length_acc_in;
         absolute_tick_ff  <= absolute_tick_in;
         first_data_ff     <= first_data_in;
         skip_remaining_ff <= skip_remaining_in;
         meta_kind_ff      <= meta_kind_in;
         track_index_ff    <= track_index_in;
         notes_seen_ff     <= notes_seen_in;
      end
   end

endmodule

@@ rtl/core/mtcp_output_stage.sv @@
// Result register of the MIDI track chunk parser.
// Depends on mtcp_pkg for the result struct.
module mtcp_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 res_valid,
   input  mtcp_pkg::result_type res,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mtcp_pkg::result_type rsp
);

   logic                 valid_ff, valid_in;
   mtcp_pkg::result_type data_ff;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = res_valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

@@ rtl/core/midi_track_chunk_parser.sv @@
// Top level of the MIDI track chunk parser: input register, parser, result register.
// Depends on mtcp_pkg, mtcp_input_stage, mtcp_parser and mtcp_output_stage.
//
// The block takes one byte of a Standard MIDI File track chunk stream per transaction,
// header bytes included, and reports note-on, note-off, end-of-track and bad-header
// events. It accepts one byte every cycle while it is not stalled by a waiting result;
// a byte is held in the input register until the parser takes it, and its event, if
// any, is registered in the result register and shown on the rsp_ channel. The
// throughput is set by the single parser state update per byte, and it holds at one
// byte per cycle as long as results are taken when they are shown.
module midi_track_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [31:0] rsp_start_tick,
   output logic [6:0]  rsp_key,
   output logic [6:0]  rsp_velocity,
   output logic [15:0] rsp_track_number,
   output logic [31:0] rsp_note_count
);

   logic                 item_valid;
   logic [7:0]           item_data_byte;
   logic                 item_stream_start;
   logic                 space;
   logic                 step;
   logic                 res_valid;
   mtcp_pkg::result_type res;
   mtcp_pkg::result_type rsp;

   assign step = item_valid && space;

   mtcp_input_stage u_input (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_stream_start  (req_stream_start),
      .take              (step),
      .item_valid        (item_valid),
      .item_data_byte    (item_data_byte),
      .item_stream_start (item_stream_start)
   );

   mtcp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (item_data_byte),
      .stream_start (item_stream_start),
      .res_valid    (res_valid),
      .res          (res)
   );

   mtcp_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_event_kind   = rsp.event_kind;
   assign rsp_channel      = rsp.channel;
   assign rsp_start_tick   = rsp.start_tick;
   assign rsp_key          = rsp.key;
   assign rsp_velocity     = rsp.velocity;
   assign rsp_track_number = rsp.track_number;
   assign rsp_note_count   = rsp.note_count;

endmodule

@@ rtl/core/mtcp_checker.sv @@
// Port-level checker for the MIDI track chunk parser, bound to the top level.
// Depends on mtcp_pkg for the event codes and on midi_track_chunk_parser.
module mtcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [3:0]  rsp_channel,
   input logic [31:0] rsp_start_tick,
   input logic [6:0]  rsp_key,
   input logic [6:0]  rsp_velocity
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_start_tick))
      else $error("Stalled result transaction changed.");

   a_bad_header_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == mtcp_pkg::EV_BAD_HDR |->
      rsp_channel == 4'd0 && rsp_start_tick == 32'd0 && rsp_key == 7'd0 &&
      rsp_velocity == 7'd0)
      else $error("Bad-header event carries note fields.");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == mtcp_pkg::EV_END |->
      rsp_channel == 4'd0 && rsp_key == 7'd0 && rsp_velocity == 7'd0)
      else $error("End-of-track event carries note fields.");

   a_note_on_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == mtcp_pkg::EV_NOTE_ON |-> rsp_velocity != 7'd0)
      else $error("Note-on reported with zero velocity.");

endmodule

bind midi_track_chunk_parser mtcp_checker u_mtcp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_kind (rsp_event_kind),
   .rsp_channel    (rsp_channel),
   .rsp_start_tick (rsp_start_tick),
   .rsp_key        (rsp_key),
   .rsp_velocity   (rsp_velocity)
);

@@ tb/tb_midi_track_chunk_parser.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for midi_track_chunk_parser: random track chunks drive req_,
// a scoreboard class predicts every rsp_ transaction. Depends on mtcp_pkg and the RTL.
module tb_midi_track_chunk_parser;

   localparam logic [7:0] TRACK_TAG [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};
   localparam logic [3:0] HI_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] HI_CONTROL       = 4'hB;
   localparam logic [3:0] HI_PITCH_BEND    = 4'hE;
   localparam logic [7:0] META_TEMPO       = 8'h51;
   localparam logic [7:0] META_TIME_SIG    = 8'h58;
   localparam logic [7:0] META_KEY_SIG     = 8'h59;
   localparam logic [7:0] META_TEXT        = 8'h01;
   localparam logic [7:0] SYS_FIRST        = 8'hF1;
   localparam logic [7:0] SYS_LAST         = 8'hFE;
   localparam int         STREAM_TARGET    = 1900;
   localparam logic [7:0] OPENING_BYTES [31] = '{
      8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h0F,
      8'h00, 8'h9F, 8'h7F, 8'h7F,
      8'h81, 8'h00, 8'h7F, 8'h00,
      8'h00, 8'hC3, 8'h05,
      8'h00, 8'hFF, 8'h2F, 8'h00
   };

   class track_event_scoreboard;
      mtcp_pkg::phase_type  phase;
      logic [2:0]           hdr_idx;
      logic [31:0]          chunk_len;
      logic [31:0]          body_count;
      logic [7:0]           run_status;
      logic [31:0]          vlq;
      logic [31:0]          tick;
      logic [6:0]           data1;
      logic [31:0]          skip_left;
      logic [15:0]          track_idx;
      logic [31:0]          notes_on;
      mtcp_pkg::result_type expected_events[$];
      int                   errors;
      int                   checked;

      function new();
         errors = 0;
         checked = 0;
         clear();
      endfunction

      function void clear();
         phase = mtcp_pkg::PH_HDR;
         hdr_idx = '0;
         chunk_len = '0;
         body_count = '0;
         run_status = '0;
         vlq = '0;
         tick = '0;
         data1 = '0;
         skip_left = '0;
         track_idx = '0;
         notes_on = '0;
      endfunction

      function void add_event(logic [1:0] kind, logic [3:0] ch, logic [31:0] at_tick,
                              logic [6:0] key, logic [6:0] vel);
         mtcp_pkg::result_type r;
         r.event_kind = kind;
         r.channel = ch;
         r.start_tick = at_tick;
         r.key = key;
         r.velocity = vel;
         r.track_number = track_idx;
         r.note_count = notes_on;
         expected_events.insert(expected_events.size(), r);
      endfunction

      function void start_delta();
         vlq = '0;
         phase = mtcp_pkg::PH_DELTA;
      endfunction

      function void take_first(logic [7:0] b);
         data1 = b[6:0];
         if (run_status[7:4] == mtcp_pkg::HI_PROGRAM ||
             run_status[7:4] == mtcp_pkg::HI_PRESSURE) start_delta();
         else phase = mtcp_pkg::PH_DATA2;
      endfunction

      function void take_byte(logic [7:0] b, logic start);
         logic [6:0] vel;
         if (start) clear();
         if (phase == mtcp_pkg::PH_HDR || phase == mtcp_pkg::PH_HDR_BAD) begin
            if (hdr_idx == 0) chunk_len = '0;
            if (hdr_idx < 4) begin
               if (b != TRACK_TAG[hdr_idx[1:0]]) phase = mtcp_pkg::PH_HDR_BAD;
            end else begin
               chunk_len = {chunk_len[23:0], b};
            end
            if (hdr_idx == 7) begin
               hdr_idx = '0;
               if (phase == mtcp_pkg::PH_HDR_BAD) begin
                  add_event(mtcp_pkg::EV_BAD_HDR, '0, '0, '0, '0);
                  phase = mtcp_pkg::PH_HDR;
               end else if (chunk_len == 0) begin
                  track_idx = track_idx + 1'b1;
               end else begin
                  body_count = '0;
                  tick = '0;
                  run_status = '0;
                  start_delta();
               end
            end else begin
               hdr_idx = hdr_idx + 1'b1;
            end
            return;
         end
         case (phase)
            mtcp_pkg::PH_DELTA: begin
               vlq = {vlq[24:0], b[6:0]};
               if (!b[7]) begin
                  tick = tick + vlq;
                  phase = mtcp_pkg::PH_STATUS;
               end
            end
            mtcp_pkg::PH_STATUS: begin
               if (!b[7]) begin
                  if (run_status != 0) take_first(b);
                  else start_delta();
               end else if (b < mtcp_pkg::ST_SYSEX) begin
                  run_status = b;
                  phase = mtcp_pkg::PH_DATA1;
               end else begin
                  run_status = '0;
                  vlq = '0;
                  if (b == mtcp_pkg::ST_META) phase = mtcp_pkg::PH_META;
                  else if (b == mtcp_pkg::ST_SYSEX || b == mtcp_pkg::ST_SYSEX_ESC)
                     phase = mtcp_pkg::PH_LEN;
                  else start_delta();
               end
            end
            mtcp_pkg::PH_DATA1: take_first(b);
            mtcp_pkg::PH_DATA2: begin
               vel = b[6:0];
               if (run_status[7:4] == mtcp_pkg::HI_NOTE_OFF) begin
                  add_event(mtcp_pkg::EV_NOTE_OFF, run_status[3:0], tick, data1, vel);
               end else if (run_status[7:4] == mtcp_pkg::HI_NOTE_ON) begin
                  if (vel != 0) begin
                     notes_on = notes_on + 1;
                     add_event(mtcp_pkg::EV_NOTE_ON, run_status[3:0], tick, data1, vel);
                  end else begin
                     add_event(mtcp_pkg::EV_NOTE_OFF, run_status[3:0], tick, data1, '0);
                  end
               end
               start_delta();
            end
            mtcp_pkg::PH_META: begin
               if (b == mtcp_pkg::META_EOT) begin
                  add_event(mtcp_pkg::EV_END, '0, tick, '0, '0);
                  phase = mtcp_pkg::PH_DRAIN;
               end else begin
                  vlq = '0;
                  phase = mtcp_pkg::PH_LEN;
               end
            end
            mtcp_pkg::PH_LEN: begin
               vlq = {vlq[24:0], b[6:0]};
               if (!b[7]) begin
                  skip_left = vlq;
                  if (vlq == 0) start_delta();
                  else phase = mtcp_pkg::PH_SKIP;
               end
            end
            mtcp_pkg::PH_SKIP: begin
               skip_left = skip_left - 1;
               if (skip_left == 0) start_delta();
            end
            default: phase = mtcp_pkg::PH_DRAIN;
         endcase
         body_count = body_count + 1;
         if (body_count == chunk_len) begin
            track_idx = track_idx + 1'b1;
            phase = mtcp_pkg::PH_HDR;
            hdr_idx = '0;
            tick = '0;
            run_status = '0;
            vlq = '0;
            skip_left = '0;
            body_count = '0;
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check_event(mtcp_pkg::result_type got);
         mtcp_pkg::result_type exp;
         checked++;
         if (expected_events.size() == 0) begin
            $error("unexpected transaction on rsp_, event_kind %0d", got.event_kind);
            errors++;
            return;
         end
         exp = expected_events.pop_front();
         compare_field("event_kind", exp.event_kind, got.event_kind);
         compare_field("channel", exp.channel, got.channel);
         compare_field("start_tick", exp.start_tick, got.start_tick);
         compare_field("key", exp.key, got.key);
         compare_field("velocity", exp.velocity, got.velocity);
         compare_field("track_number", exp.track_number, got.track_number);
         compare_field("note_count", exp.note_count, got.note_count);
      endfunction

      function void report_leftover();
         if (expected_events.size() != 0) begin
            $error("%0d expected events never arrived", expected_events.size());
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_stream_start;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_event_kind;
   logic [3:0]  rsp_channel;
   logic [31:0] rsp_start_tick;
   logic [6:0]  rsp_key;
   logic [6:0]  rsp_velocity;
   logic [15:0] rsp_track_number;
   logic [31:0] rsp_note_count;

   track_event_scoreboard sb = new();

   logic [7:0] stream_bytes[$];
   logic       stream_flags[$];
   logic [7:0] body_bytes[$];
   logic [7:0] gen_status;

   midi_track_chunk_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_channel      (rsp_channel),
      .rsp_start_tick   (rsp_start_tick),
      .rsp_key          (rsp_key),
      .rsp_velocity     (rsp_velocity),
      .rsp_track_number (rsp_track_number),
      .rsp_note_count   (rsp_note_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void push_stream(logic [7:0] b, logic s);
      stream_bytes.insert(stream_bytes.size(), b);
      stream_flags.insert(stream_flags.size(), s);
   endfunction

   function automatic void put_body(logic [7:0] b);
      body_bytes.insert(body_bytes.size(), b);
   endfunction

   function automatic void push_vlq(logic [31:0] v);
      logic [7:0] grp[$];
      grp.push_front({1'b0, v[6:0]});
      v = v >> 7;
      while (v != 0) begin
         grp.push_front({1'b1, v[6:0]});
         v = v >> 7;
      end
      foreach (grp[i]) put_body(grp[i]);
   endfunction

   function automatic void push_delta();
      int r;
      r = $urandom_range(99);
      if (r < 50) push_vlq(0);
      else if (r < 90) push_vlq($urandom_range(1, 127));
      else if (r < 98) push_vlq($urandom_range(128, 2097151));
      else begin
         repeat (5) put_body({1'b1, 7'($urandom_range(127))});
         put_body({1'b0, 7'($urandom_range(127))});
      end
   endfunction

   function automatic void push_channel_msg();
      logic [3:0] hi;
      logic [7:0] st;
      logic [7:0] d;
      bit         running;
      case ($urandom_range(8))
         0:       hi = mtcp_pkg::HI_NOTE_OFF;
         1, 2, 3: hi = mtcp_pkg::HI_NOTE_ON;
         4:       hi = HI_POLY_PRESSURE;
         5:       hi = HI_CONTROL;
         6:       hi = mtcp_pkg::HI_PROGRAM;
         7:       hi = mtcp_pkg::HI_PRESSURE;
         default: hi = HI_PITCH_BEND;
      endcase
      st = {hi, 4'($urandom_range(15))};
      running = (gen_status[7:4] == hi) && ($urandom_range(1) == 1);
      if (!running) begin
         put_body(st);
         gen_status = st;
      end
      d = 8'($urandom_range(127));
      if (!running && $urandom_range(19) == 0) d[7] = 1'b1;
      put_body(d);
      if (hi != mtcp_pkg::HI_PROGRAM && hi != mtcp_pkg::HI_PRESSURE) begin
         if (hi == mtcp_pkg::HI_NOTE_ON && $urandom_range(4) == 0) d = 8'h00;
         else d = 8'($urandom_range(127));
         if (!running && $urandom_range(19) == 0) d[7] = 1'b1;
         put_body(d);
      end
   endfunction

   function automatic void push_meta();
      logic [7:0]  kind;
      logic [31:0] len;
      case ($urandom_range(4))
         0: begin kind = META_TEMPO;    len = 3; end
         1: begin kind = META_TIME_SIG; len = 4; end
         2: begin kind = META_KEY_SIG;  len = 2; end
         3: begin kind = META_TEXT;     len = $urandom_range(6); end
         default: begin
            kind = 8'($urandom_range(255));
            if (kind == mtcp_pkg::META_EOT) kind = mtcp_pkg::META_EOT - 8'd1;
            len = $urandom_range(4);
         end
      endcase
      put_body(mtcp_pkg::ST_META);
      put_body(kind);
      if ($urandom_range(29) == 0) begin
         push_vlq($urandom());
      end else begin
         push_vlq(len);
         repeat (len) put_body(8'($urandom_range(255)));
      end
      gen_status = '0;
   endfunction

   function automatic void push_event();
      int         r;
      int         len;
      logic [7:0] b;
      r = $urandom_range(99);
      if (r < 55 || r >= 92) begin
         push_channel_msg();
      end else if (r < 68) begin
         push_meta();
      end else if (r < 76) begin
         put_body($urandom_range(1) ? mtcp_pkg::ST_SYSEX : mtcp_pkg::ST_SYSEX_ESC);
         len = $urandom_range(6);
         push_vlq(len);
         repeat (len) put_body(8'($urandom_range(255)));
         gen_status = '0;
      end else if (r < 84) begin
         b = 8'($urandom_range(SYS_FIRST, SYS_LAST));
         if (b == mtcp_pkg::ST_SYSEX_ESC) b = SYS_FIRST;
         put_body(b);
         gen_status = '0;
      end else if (gen_status == 0) begin
         put_body(8'($urandom_range(127)));
      end else begin
         push_channel_msg();
      end
   endfunction

   function automatic void push_chunk();
      int          r;
      int          len;
      int          start_pos;
      int          bad_pos;
      logic        first_start;
      logic [7:0]  tag[4];
      logic [31:0] hdr_len;
      r = $urandom_range(99);
      first_start = ($urandom_range(9) == 0);
      tag = TRACK_TAG;
      if (r < 8) begin
         bad_pos = $urandom_range(3);
         tag[bad_pos] = tag[bad_pos] ^ 8'($urandom_range(1, 255));
         foreach (tag[i]) push_stream(tag[i], (i == 0) && first_start);
         repeat (4) push_stream(8'($urandom_range(255)), 1'b0);
         return;
      end
      if (r < 13) begin
         foreach (tag[i]) push_stream(tag[i], (i == 0) && first_start);
         repeat (4) push_stream(8'h00, 1'b0);
         return;
      end
      body_bytes.delete();
      gen_status = '0;
      repeat ($urandom_range(1, 12)) begin
         push_delta();
         push_event();
      end
      if ($urandom_range(4) != 0) begin
         push_vlq($urandom_range(3) == 0 ? $urandom_range(1, 300) : 0);
         put_body(mtcp_pkg::ST_META);
         put_body(mtcp_pkg::META_EOT);
         put_body(8'h00);
         repeat ($urandom_range(3)) put_body(8'($urandom_range(255)));
      end
      len = body_bytes.size();
      if ($urandom_range(9) == 0 && len > 1)
         len = len - $urandom_range(1, (len > 5) ? 4 : len - 1);
      start_pos = ($urandom_range(49) == 0) ? $urandom_range(len - 1) : -1;
      hdr_len = len;
      foreach (tag[i]) push_stream(tag[i], (i == 0) && first_start);
      push_stream(hdr_len[31:24], 1'b0);
      push_stream(hdr_len[23:16], 1'b0);
      push_stream(hdr_len[15:8], 1'b0);
      push_stream(hdr_len[7:0], 1'b0);
      for (int i = 0; i < len; i++) push_stream(body_bytes[i], i == start_pos);
   endfunction

   task automatic send_byte(logic [7:0] b, logic s, bit may_idle);
      int gap;
      gap = 0;
      if (may_idle) while ($urandom_range(99) < 17) gap++;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_stream_start = s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_byte(b, s);
      @(negedge clock);
   endtask

   initial begin : result_side
      int                   hold_left;
      bit                   held_once;
      mtcp_pkg::result_type got;
      hold_left = 0;
      held_once = 0;
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         // Long hold-off so the block backs up and stalls req_ready.
         if (!held_once && sb.checked == 60) begin
            held_once = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (sb.checked >= 200 && sb.checked < 400) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(99) >= 17);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.event_kind = rsp_event_kind;
            got.channel = rsp_channel;
            got.start_tick = rsp_start_tick;
            got.key = rsp_key;
            got.velocity = rsp_velocity;
            got.track_number = rsp_track_number;
            got.note_count = rsp_note_count;
            sb.check_event(got);
         end
      end
   end

   initial begin : byte_side
      req_valid = 1'b0;
      req_data_byte = '0;
      req_stream_start = 1'b0;
      foreach (OPENING_BYTES[i]) push_stream(OPENING_BYTES[i], i == 0);
      while (stream_bytes.size() < STREAM_TARGET) push_chunk();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], stream_flags[i], i < 700 || i >= 1000);
      req_valid = 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.report_leftover();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mtcp_pkg.sv
rtl/core/mtcp_input_stage.sv
rtl/core/mtcp_parser.sv
rtl/core/mtcp_output_stage.sv
rtl/core/midi_track_chunk_parser.sv
rtl/core/mtcp_checker.sv
tb/tb_midi_track_chunk_parser.sv
